FILE: src/bsm_pkg.sv
package bsm_pkg;

    localparam int CoordWidth  = 32;
    localparam int RadiusWidth = CoordWidth - 1;
    localparam int MagWidth    = CoordWidth + 1;
    localparam int ProdWidth   = 2 * MagWidth;
    localparam int DataWidth   = 128;

    localparam logic [RadiusWidth-1:0] RadiusMax = '1;

    typedef enum logic [2:0] {
        MUL_DX2,
        MUL_DY2,
        MUL_DZ2,
        MUL_RD2,
        MUL_DXS,
        MUL_DYS,
        MUL_DZS
    } mul_sel_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_ACC_SET,
        CAP_ACC_ADD,
        CAP_RD2,
        CAP_LANE_X,
        CAP_LANE_Y,
        CAP_LANE_Z
    } cap_sel_t;

    typedef enum logic [1:0] {
        CM_KEEP,
        CM_LOAD,
        CM_GROW
    } commit_mode_t;

    typedef struct packed {
        logic         capture;
        mul_sel_t     mul_sel;
        cap_sel_t     cap_sel;
        logic         root_init;
        logic         root_step;
        logic         rad_en;
        logic         div_step;
        logic         commit;
        commit_mode_t commit_mode;
    } bsm_cmd_t;

    typedef struct packed {
        logic contain;
        logic r0_le_r1;
    } bsm_status_t;

endpackage

FILE: src/bsm_dpath.sv
module bsm_dpath import bsm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bsm_cmd_t               cmd,
    output bsm_status_t            status,
    input  logic [CoordWidth-1:0]  item_x,
    input  logic [CoordWidth-1:0]  item_y,
    input  logic [CoordWidth-1:0]  item_z,
    input  logic [RadiusWidth-1:0] item_r,
    output logic [CoordWidth-1:0]  res_x,
    output logic [CoordWidth-1:0]  res_y,
    output logic [CoordWidth-1:0]  res_z,
    output logic [RadiusWidth-1:0] res_r,
    output logic                   res_changed
);

    logic [CoordWidth-1:0]  center_reg [3];
    logic [CoordWidth-1:0]  center_next [3];
    logic [RadiusWidth-1:0] radius_reg, radius_next;
    logic                   changed_reg, changed_next;

    logic [CoordWidth-1:0]  in_c_reg [3];
    logic [RadiusWidth-1:0] in_r_reg;

    logic [MagWidth-1:0]    dmag_reg [3];
    logic                   dneg_reg [3];
    logic [RadiusWidth-1:0] rdmag_reg;

    logic [ProdWidth-1:0]   prod_reg;
    logic [ProdWidth-1:0]   acc_reg;
    logic [2*RadiusWidth-1:0] rd2_reg;

    logic [ProdWidth-1:0]   rad_reg;
    logic [MagWidth+1:0]    root_rem_reg;
    logic [MagWidth-1:0]    root_reg;

    logic [RadiusWidth-1:0] nr_reg;
    logic [RadiusWidth-1:0] step_reg;

    logic [MagWidth-1:0]    lane_rem_reg [3];
    logic [RadiusWidth-1:0] lane_q_reg [3];

    logic [CoordWidth-1:0]  item_c [3];
    logic [MagWidth-1:0]    mul_a, mul_b;

    logic [MagWidth+3:0]    rem_sh, trial;
    logic [MagWidth:0]      rad_sum;
    logic [MagWidth-1:0]    nr_wide;
    logic [RadiusWidth-1:0] nr_sat;

    assign item_c[0] = item_x;
    assign item_c[1] = item_y;
    assign item_c[2] = item_z;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_DX2: begin mul_a = dmag_reg[0]; mul_b = dmag_reg[0]; end
            MUL_DY2: begin mul_a = dmag_reg[1]; mul_b = dmag_reg[1]; end
            MUL_DZ2: begin mul_a = dmag_reg[2]; mul_b = dmag_reg[2]; end
            MUL_RD2: begin
                mul_a = {2'b00, rdmag_reg};
                mul_b = {2'b00, rdmag_reg};
            end
            MUL_DXS: begin mul_a = dmag_reg[0]; mul_b = {2'b00, step_reg}; end
            MUL_DYS: begin mul_a = dmag_reg[1]; mul_b = {2'b00, step_reg}; end
            MUL_DZS: begin mul_a = dmag_reg[2]; mul_b = {2'b00, step_reg}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // One root digit per step: two radicand bits enter the partial remainder.
    assign rem_sh = {root_rem_reg, rad_reg[ProdWidth-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    assign rad_sum = {1'b0, root_reg} + {3'b000, radius_reg} + {3'b000, in_r_reg};
    assign nr_wide = rad_sum[MagWidth:1];
    assign nr_sat  = (nr_wide > {2'b00, RadiusMax}) ? RadiusMax : nr_wide[RadiusWidth-1:0];

    always_comb begin
        logic signed [CoordWidth+1:0] moved;
        logic signed [CoordWidth+1:0] cmax, cmin;
        cmax = (CoordWidth+2)'(signed'({1'b0, {(CoordWidth-1){1'b1}}}));
        cmin = -cmax - 1;
        for (int i = 0; i < 3; i++) begin
            moved = (CoordWidth+2)'(signed'(center_reg[i]));
            if (dneg_reg[i]) begin
                moved = moved - (CoordWidth+2)'(lane_q_reg[i]);
            end else begin
                moved = moved + (CoordWidth+2)'(lane_q_reg[i]);
            end
            if (moved > cmax) begin
                moved = cmax;
            end else if (moved < cmin) begin
                moved = cmin;
            end
            case (cmd.commit_mode)
                CM_LOAD: center_next[i] = in_c_reg[i];
                CM_GROW: center_next[i] = moved[CoordWidth-1:0];
                default: center_next[i] = center_reg[i];
            endcase
        end
        case (cmd.commit_mode)
            CM_LOAD: radius_next = in_r_reg;
            CM_GROW: radius_next = nr_reg;
            default: radius_next = radius_reg;
        endcase
        changed_next = (center_next[0] != center_reg[0]) || (center_next[1] != center_reg[1])
                    || (center_next[2] != center_reg[2]) || (radius_next != radius_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                center_reg[i] <= '0;
            end
            radius_reg  <= '0;
            changed_reg <= 1'b0;
        end else if (cmd.commit) begin
            for (int i = 0; i < 3; i++) begin
                center_reg[i] <= center_next[i];
            end
            radius_reg  <= radius_next;
            changed_reg <= changed_next;
        end
    end

    always_ff @(posedge aclk) begin
        logic [MagWidth:0]     sh;
        logic                  ge;
        logic signed [MagWidth-1:0] d;
        logic signed [RadiusWidth:0] rd;
        if (cmd.capture) begin
            for (int i = 0; i < 3; i++) begin
                in_c_reg[i] <= item_c[i];
                d = MagWidth'(signed'(item_c[i])) - MagWidth'(signed'(center_reg[i]));
                dneg_reg[i] <= d[MagWidth-1];
                dmag_reg[i] <= d[MagWidth-1] ? MagWidth'(-d) : MagWidth'(d);
            end
            in_r_reg <= item_r;
            rd = {1'b0, item_r} - {1'b0, radius_reg};
            rdmag_reg <= rd[RadiusWidth] ? RadiusWidth'(-rd) : RadiusWidth'(rd);
        end

        prod_reg <= mul_a * mul_b;

        case (cmd.cap_sel)
            CAP_ACC_SET: acc_reg <= prod_reg;
            CAP_ACC_ADD: acc_reg <= acc_reg + prod_reg;
            CAP_RD2:     rd2_reg <= prod_reg[2*RadiusWidth-1:0];
            CAP_LANE_X: begin
                lane_rem_reg[0] <= prod_reg[RadiusWidth+MagWidth-1:RadiusWidth];
                lane_q_reg[0]   <= prod_reg[RadiusWidth-1:0];
            end
            CAP_LANE_Y: begin
                lane_rem_reg[1] <= prod_reg[RadiusWidth+MagWidth-1:RadiusWidth];
                lane_q_reg[1]   <= prod_reg[RadiusWidth-1:0];
            end
            CAP_LANE_Z: begin
                lane_rem_reg[2] <= prod_reg[RadiusWidth+MagWidth-1:RadiusWidth];
                lane_q_reg[2]   <= prod_reg[RadiusWidth-1:0];
            end
            default: ;
        endcase

        if (cmd.root_init) begin
            rad_reg      <= acc_reg;
            root_rem_reg <= '0;
            root_reg     <= '0;
        end else if (cmd.root_step) begin
            rad_reg <= {rad_reg[ProdWidth-3:0], 2'b00};
            if (rem_sh >= trial) begin
                root_rem_reg <= (MagWidth+2)'(rem_sh - trial);
                root_reg     <= {root_reg[MagWidth-2:0], 1'b1};
            end else begin
                root_rem_reg <= rem_sh[MagWidth+1:0];
                root_reg     <= {root_reg[MagWidth-2:0], 1'b0};
            end
        end

        if (cmd.rad_en) begin
            nr_reg   <= nr_sat;
            step_reg <= nr_sat - radius_reg;
        end

        // Restoring division, three lanes sharing the distance as divisor.
        if (cmd.div_step) begin
            for (int i = 0; i < 3; i++) begin
                sh = {lane_rem_reg[i], lane_q_reg[i][RadiusWidth-1]};
                ge = sh >= {1'b0, root_reg};
                lane_rem_reg[i] <= ge ? MagWidth'(sh - {1'b0, root_reg}) : sh[MagWidth-1:0];
                lane_q_reg[i]   <= {lane_q_reg[i][RadiusWidth-2:0], ge};
            end
        end
    end

    assign status.contain  = {4'b0000, rd2_reg} >= acc_reg;
    assign status.r0_le_r1 = radius_reg <= in_r_reg;

    assign res_x       = center_reg[0];
    assign res_y       = center_reg[1];
    assign res_z       = center_reg[2];
    assign res_r       = radius_reg;
    assign res_changed = changed_reg;

    a_div_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (lane_rem_reg[0] < root_reg) && (lane_rem_reg[1] < root_reg)
                         && (lane_rem_reg[2] < root_reg))
        else $error("division remainder not below distance");

    a_root_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.root_step |-> root_rem_reg <= {1'b0, root_reg, 1'b0})
        else $error("square root remainder out of bound");

    a_grow_no_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && cmd.commit_mode == CM_GROW) |-> nr_reg >= radius_reg)
        else $error("growth step shrank the radius");

endmodule

FILE: src/bsm_ctrl.sv
module bsm_ctrl import bsm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output bsm_cmd_t    cmd,
    input  bsm_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_CMP,
        ST_ROOT,
        ST_RAD,
        ST_PROD,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam int CntWidth = 6;
    localparam logic [CntWidth-1:0] SqrLast  = CntWidth'(4);
    localparam logic [CntWidth-1:0] RootLast = CntWidth'(MagWidth - 1);
    localparam logic [CntWidth-1:0] ProdLast = CntWidth'(3);
    localparam logic [CntWidth-1:0] DivLast  = CntWidth'(RadiusWidth - 1);

    state_t               state_reg, state_next;
    logic [CntWidth-1:0]  cnt_reg, cnt_next;
    commit_mode_t         mode_reg, mode_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd             = '0;
        cmd.mul_sel     = MUL_DX2;
        cmd.cap_sel     = CAP_NONE;
        cmd.commit_mode = mode_reg;
        state_next      = state_reg;
        cnt_next        = cnt_reg + 1'b1;
        mode_next       = mode_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (s_tuser) begin
                        mode_next  = CM_LOAD;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                case (cnt_reg[2:0])
                    3'd0: cmd.mul_sel = MUL_DX2;
                    3'd1: begin cmd.mul_sel = MUL_DY2; cmd.cap_sel = CAP_ACC_SET; end
                    3'd2: begin cmd.mul_sel = MUL_DZ2; cmd.cap_sel = CAP_ACC_ADD; end
                    3'd3: begin cmd.mul_sel = MUL_RD2; cmd.cap_sel = CAP_ACC_ADD; end
                    default: cmd.cap_sel = CAP_RD2;
                endcase
                if (cnt_reg == SqrLast) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cnt_next = '0;
                if (status.contain) begin
                    mode_next  = status.r0_le_r1 ? CM_LOAD : CM_KEEP;
                    state_next = ST_DONE;
                end else begin
                    cmd.root_init = 1'b1;
                    state_next    = ST_ROOT;
                end
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (cnt_reg == RootLast) begin
                    state_next = ST_RAD;
                end
            end
            ST_RAD: begin
                cmd.rad_en = 1'b1;
                cnt_next   = '0;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                case (cnt_reg[1:0])
                    2'd0: cmd.mul_sel = MUL_DXS;
                    2'd1: begin cmd.mul_sel = MUL_DYS; cmd.cap_sel = CAP_LANE_X; end
                    2'd2: begin cmd.mul_sel = MUL_DZS; cmd.cap_sel = CAP_LANE_Y; end
                    default: cmd.cap_sel = CAP_LANE_Z;
                endcase
                if (cnt_reg == ProdLast) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DivLast) begin
                    mode_next  = CM_GROW;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            mode_reg     <= CM_KEEP;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            mode_reg     <= mode_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_commit_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid_reg || m_tready))
        else $error("result committed over a pending one");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg)
        else $error("committed result not presented");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared outside the commit state");

endmodule

FILE: src/bounding_sphere_merge.sv
// Running bounding sphere. Each input transfer carries one sphere (center and
// radius, Q16.16; a point has radius 0). With s_tuser set the sphere is loaded
// as is; otherwise it is merged into the stored sphere, which grows just
// enough to hold both. Every input transfer yields one output transfer with
// the stored sphere after the update and, in m_tuser, a flag that is set when
// any stored bit changed.
// A load goes straight to the commit. A merge whose item lies inside or
// encloses the stored sphere commits after the squares and the compare; a
// growing merge also runs the 33-step square root of the squared center
// distance and the 31-step division, run for all three axes at once. One
// item is worked on at a time.
// A finished result waits in the output register while the next item is
// already accepted and worked on; its update is held back until the receiver
// has taken the earlier transfer. m_tdata stays stable while stalled.
// Reset (aresetn low at a clock edge) clears the stored sphere to the origin
// with radius 0 and drops any pending result.
module bounding_sphere_merge import bsm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // in_x [31:0], in_y [63:32], in_z [95:64], in_radius [126:96], zero pad
    input  logic [DataWidth-1:0] s_tdata,
    // load
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_x [31:0], out_y [63:32], out_z [95:64], out_radius [126:96], zero pad
    output logic [DataWidth-1:0] m_tdata,
    // changed
    output logic                 m_tuser
);

    bsm_cmd_t               cmd;
    bsm_status_t            status;
    logic [CoordWidth-1:0]  res_x, res_y, res_z;
    logic [RadiusWidth-1:0] res_r;

    // The sequencer steps the shared multiplier, root and divider lanes.
    bsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // The stored sphere doubles as the output register: it only changes
    // when the output slot is free.
    bsm_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .item_x      (s_tdata[CoordWidth-1:0]),
        .item_y      (s_tdata[2*CoordWidth-1:CoordWidth]),
        .item_z      (s_tdata[3*CoordWidth-1:2*CoordWidth]),
        .item_r      (s_tdata[3*CoordWidth+RadiusWidth-1:3*CoordWidth]),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_z       (res_z),
        .res_r       (res_r),
        .res_changed (m_tuser)
    );

    assign m_tdata = {{(DataWidth-3*CoordWidth-RadiusWidth){1'b0}}, res_r, res_z, res_y, res_x};

endmodule
